// ----- design/paced_kalman_sensor_scaler_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the paced Kalman sensor scaler
// Concurrent checks on i_clk, disabled while i_rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef PACED_KALMAN_SENSOR_SCALER_UNIT_ASSERT_SVH
`define PACED_KALMAN_SENSOR_SCALER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PKSU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PKSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PKSU_ASSERT_IMPL(lbl, ante, cons, msg)
`define PKSU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- design/pksu_pkg.sv -----
// ----------------------------------------------------------------------------
// pksu_pkg
// Shared constants, codes and control types of the paced Kalman sensor scaler.
// ----------------------------------------------------------------------------
package pksu_pkg;

    // default widths
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF   = 16;

    // fixed field widths
    localparam int TIME_W     = 32;
    localparam int ERR_W      = 32;
    localparam int DIV_W      = ERR_W + 1;
    localparam int GAIN_FRAC  = 16;
    localparam int GAIN_W     = GAIN_FRAC + 1;
    localparam int MAP_BITS   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [GAIN_W-1:0]   GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;
    localparam logic [MAP_BITS-1:0] MAP_MAX  = '1;

    // register reset values
    localparam logic [ERR_W-1:0] RST_MEASURE_ERR = 32'd131072;
    localparam logic [ERR_W-1:0] RST_INIT_ERR    = 32'd131072;
    localparam logic [ERR_W-1:0] RST_NOISE       = 32'd6554;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTERVAL   = 3'd0,
        REG_CLAMP_LOW  = 3'd1,
        REG_CLAMP_HIGH = 3'd2,
        REG_MEASURE    = 3'd3,
        REG_INIT_ERR   = 3'd4,
        REG_NOISE      = 3'd5
    } t_cfg_reg;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_KSTART,
        S_KDIV,
        S_MSTEP,
        S_MERR,
        S_MQHI,
        S_MQLO,
        S_NOISE,
        S_EUPD,
        S_MSTART,
        S_MDIV,
        S_MFIN,
        S_OUT
    } t_state;

    // shared multiplier operand selection
    typedef enum logic [1:0] {
        MUL_STEP,
        MUL_ERR,
        MUL_NOISE_HI,
        MUL_NOISE_LO
    } t_mul_op;

    // sequencer to datapath
    typedef struct packed {
        logic    in_ready;
        logic    out_valid;
        logic    k_load;
        logic    k_latch;
        logic    x_upd;
        logic    ne1_upd;
        logic    hi_upd;
        logic    noise_upd;
        logic    e_upd;
        logic    m_load;
        logic    s_upd;
        t_mul_op mul_op;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic take;
        logic div_busy;
        logic div_done;
    } t_stat;

endpackage

// ----- design/pksu_if.sv -----
// ----------------------------------------------------------------------------
// pksu channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface pksu_item_if import pksu_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [TIME_W-1:0]      now_ms;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   force_req;

    modport source (output valid, now_ms, sample, force_req, input ready);
    modport sink   (input valid, now_ms, sample, force_req, output ready);
endinterface

interface pksu_result_if import pksu_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   taken;
    logic [SAMPLE_BITS-1:0] filtered_value;
    logic [MAP_BITS-1:0]    scaled_value;

    modport source (output valid, taken, filtered_value, scaled_value, input ready);
    modport sink   (input valid, taken, filtered_value, scaled_value, output ready);
endinterface

interface pksu_cfg_if import pksu_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/pksu_mul.sv -----
// ----------------------------------------------------------------------------
// pksu_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module pksu_mul import pksu_pkg::*; #(
    parameter int A_W = ERR_W,
    parameter int B_W = GAIN_W
) (
    input  logic               i_clk,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_p
);

    logic [A_W+B_W-1:0] r_p;

    // register the product
    always_ff @(posedge i_clk) begin
        r_p <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- design/pksu_div.sv -----
// ----------------------------------------------------------------------------
// pksu_div
// Restoring divider, one quotient bit per cycle, shared by gain and mapping.
// ----------------------------------------------------------------------------
module pksu_div import pksu_pkg::*; #(
    parameter int QUO_W = 18
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [DIV_W-1:0]             i_rem,
    input  logic [QUO_W-1:0]             i_dvd,
    input  logic [DIV_W-1:0]             i_dsr,
    input  logic [$clog2(QUO_W+1)-1:0]   i_steps,
    output logic [QUO_W-1:0]             o_quo,
    output logic                         o_busy,
    output logic                         o_done
);

    localparam int CNT_W = $clog2(QUO_W+1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [QUO_W-1:0] r_dvd;
    logic [DIV_W-1:0] r_dsr;
    logic [QUO_W-1:0] r_quo;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             fits;

    // bring down the next dividend bit and trial-subtract
    always_comb begin
        shifted = {r_rem, r_dvd[QUO_W-1]};
        diff    = shifted - {1'b0, r_dsr};
        fits    = shifted >= {1'b0, r_dsr};
    end

    // count steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // advance remainder, dividend and quotient
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= i_rem;
            r_dvd <= i_dvd;
            r_dsr <= i_dsr;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            r_dvd <= r_dvd << 1;
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    assign o_quo  = r_quo;
    assign o_busy = r_busy;
    assign o_done = r_busy && (r_cnt == CNT_W'(1));

endmodule

// ----- design/pksu_ctrl.sv -----
// ----------------------------------------------------------------------------
// pksu_ctrl
// Sequencer: gain, filter, error and mapping for a taken word; skip to result.
// ----------------------------------------------------------------------------
module pksu_ctrl import pksu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_item_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_state = i_stat.take ? S_KSTART : S_OUT;
                end
            end
            S_KSTART: n_state = S_KDIV;
            S_KDIV: begin
                if (i_stat.div_done) begin
                    n_state = S_MSTEP;
                end
            end
            S_MSTEP:  n_state = S_MERR;
            S_MERR:   n_state = S_MQHI;
            S_MQHI:   n_state = S_MQLO;
            S_MQLO:   n_state = S_NOISE;
            S_NOISE:  n_state = S_EUPD;
            S_EUPD:   n_state = S_MSTART;
            S_MSTART: n_state = S_MDIV;
            S_MDIV: begin
                if (i_stat.div_done) begin
                    n_state = S_MFIN;
                end
            end
            S_MFIN: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // decode controls
    always_comb begin
        o_ctrl = '0;
        o_ctrl.mul_op = MUL_STEP;
        case (r_state)
            S_IDLE:   o_ctrl.in_ready  = 1'b1;
            S_KSTART: o_ctrl.k_load    = 1'b1;
            S_KDIV:   o_ctrl.mul_op    = MUL_STEP;
            S_MSTEP: begin
                o_ctrl.k_latch = 1'b1;
                o_ctrl.mul_op  = MUL_STEP;
            end
            S_MERR: begin
                o_ctrl.x_upd  = 1'b1;
                o_ctrl.mul_op = MUL_ERR;
            end
            S_MQHI: begin
                o_ctrl.ne1_upd = 1'b1;
                o_ctrl.mul_op  = MUL_NOISE_HI;
            end
            S_MQLO: begin
                o_ctrl.hi_upd = 1'b1;
                o_ctrl.mul_op = MUL_NOISE_LO;
            end
            S_NOISE:  o_ctrl.noise_upd = 1'b1;
            S_EUPD:   o_ctrl.e_upd     = 1'b1;
            S_MSTART: o_ctrl.m_load    = 1'b1;
            S_MDIV:   o_ctrl.mul_op    = MUL_STEP;
            S_MFIN:   o_ctrl.s_upd     = 1'b1;
            S_OUT:    o_ctrl.out_valid = 1'b1;
            default:  o_ctrl.mul_op    = MUL_STEP;
        endcase
    end

endmodule

// ----- design/paced_kalman_sensor_scaler_unit.sv -----
// ----------------------------------------------------------------------------
// paced_kalman_sensor_scaler_unit
// Paced sampler with a scalar Kalman filter and a linear 0..255 mapping.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  i_item    in   valid/ready   now_ms, sample, force_req
//  o_result  out  valid/ready   taken, filtered_value, scaled_value
//  i_cfg     in   valid/ready   index, data (ready high out of reset)
//
//  A taken word passes in sequence from accept to its result: a divider
//  load and 17 gain steps, four products through the shared multiplier
//  (step, error, noise high and low) and the error update, a second load
//  with SAMPLE_BITS + 8 mapping steps, saturation of the mapped value and
//  the result state.
//  A word that is not taken shows its result in the cycle after accept.
//  One word is in flight at a time; a stalled result holds the input off.
//  Synchronous reset loads the register defaults and resets the filter state.
// ----------------------------------------------------------------------------
`include "paced_kalman_sensor_scaler_unit_assert.svh"

module paced_kalman_sensor_scaler_unit import pksu_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pksu_item_if.sink      i_item,
    pksu_result_if.source  o_result,
    pksu_cfg_if.sink       i_cfg
);

    localparam int EST_W = SAMPLE_BITS + FRAC_BITS;
    localparam int A_W   = (EST_W > ERR_W) ? EST_W : ERR_W;
    localparam int PW    = A_W + GAIN_W;
    localparam int NUM_W = SAMPLE_BITS + MAP_BITS;
    localparam int QW    = (NUM_W > GAIN_W) ? NUM_W : GAIN_W;
    localparam int CNT_W = $clog2(QW+1);
    localparam int HP_W  = EST_W + GAIN_FRAC;
    localparam int TW    = DIV_W + FRAC_BITS;

    t_ctrl ctrl;
    t_stat stat;

    // configuration registers
    logic [TIME_W-1:0]      r_interval;
    logic [SAMPLE_BITS-1:0] r_lo;
    logic [SAMPLE_BITS-1:0] r_hi_lim;
    logic [ERR_W-1:0]       r_meas;
    logic [ERR_W-1:0]       r_noise_q;

    // filter state
    logic [TIME_W-1:0]      r_last;
    logic [EST_W-1:0]       r_x;
    logic [ERR_W-1:0]       r_e;
    logic [SAMPLE_BITS-1:0] r_held_f;
    logic [MAP_BITS-1:0]    r_held_s;
    logic                   r_out_taken;

    // working registers
    logic [TIME_W-1:0]      r_now;
    logic [SAMPLE_BITS-1:0] r_v;
    logic [EST_W-1:0]       r_d;
    logic                   r_up;
    logic                   r_sum_zero;
    logic [GAIN_W-1:0]      r_k;
    logic [EST_W-1:0]       r_step;
    logic [ERR_W-1:0]       r_ne1;
    logic [HP_W-1:0]        r_hi_prod;
    logic [ERR_W-1:0]       r_noise;
    logic                   r_map_zero;

    logic                   item_fire;
    logic                   cfg_fire;
    logic                   take_word;
    logic [TIME_W-1:0]      elapsed;
    logic [SAMPLE_BITS-1:0] clamped;
    logic [EST_W-1:0]       target;
    logic [DIV_W-1:0]       k_sum;
    logic [GAIN_W-1:0]      k_val;
    logic [A_W-1:0]         mul_a;
    logic [GAIN_W-1:0]      mul_b;
    logic [PW-1:0]          prod;
    logic [EST_W-1:0]       step_val;
    logic                   hi_ovf;
    logic [TW-1:0]          noise_total;
    logic [DIV_W-1:0]       noise_shift;
    logic [DIV_W-1:0]       err_sum;
    logic                   num_neg;
    logic                   den_neg;
    logic [SAMPLE_BITS-1:0] num_mag;
    logic [SAMPLE_BITS-1:0] den_mag;
    logic [NUM_W-1:0]       map_num;
    logic                   div_go;
    logic [DIV_W-1:0]       div_rem;
    logic [QW-1:0]          div_dvd;
    logic [DIV_W-1:0]       div_dsr;
    logic [CNT_W-1:0]       div_steps;
    logic [QW-1:0]          div_quo;

    // open the input only in idle and out of reset
    assign i_item.ready = ctrl.in_ready && i_rst_n;

    assign item_fire = i_item.valid && i_item.ready;
    assign cfg_fire  = i_cfg.valid && i_cfg.ready;

    // decide on taking the word and clamp the sample
    always_comb begin
        elapsed   = i_item.now_ms - r_last;
        take_word = i_item.force_req || (elapsed >= r_interval);
        if (i_item.sample < r_lo) begin
            clamped = r_lo;
        end else if (i_item.sample > r_hi_lim) begin
            clamped = r_hi_lim;
        end else begin
            clamped = i_item.sample;
        end
    end

    assign stat.take = take_word;

    // sequencer
    pksu_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .i_out_ready  (o_result.ready),
        .i_stat       (stat),
        .o_ctrl       (ctrl)
    );

    // register writes; ready stays high out of reset
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= '0;
            r_lo       <= '0;
            r_hi_lim   <= '1;
            r_meas     <= RST_MEASURE_ERR;
            r_noise_q  <= RST_NOISE;
        end else if (cfg_fire) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_INTERVAL:   r_interval <= i_cfg.data[TIME_W-1:0];
                REG_CLAMP_LOW:  r_lo       <= i_cfg.data[SAMPLE_BITS-1:0];
                REG_CLAMP_HIGH: r_hi_lim   <= i_cfg.data[SAMPLE_BITS-1:0];
                REG_MEASURE:    r_meas     <= i_cfg.data[ERR_W-1:0];
                REG_NOISE:      r_noise_q  <= i_cfg.data[ERR_W-1:0];
                default:        r_interval <= r_interval;
            endcase
        end
    end

    // gain operands: E + M in 33 bits, the gain value and the target V << FRAC_BITS
    always_comb begin
        k_sum  = {1'b0, r_e} + {1'b0, r_meas};
        k_val  = r_sum_zero ? '0 : div_quo[GAIN_W-1:0];
        target = EST_W'(r_v) << FRAC_BITS;
    end

    // mapping operands: signed numerator and span as magnitude and sign
    always_comb begin
        num_neg = r_held_f < r_lo;
        num_mag = num_neg ? (r_lo - r_held_f) : (r_held_f - r_lo);
        den_neg = r_hi_lim < r_lo;
        den_mag = den_neg ? (r_lo - r_hi_lim) : (r_hi_lim - r_lo);
        map_num = (NUM_W'(num_mag) << MAP_BITS) - NUM_W'(num_mag);
    end

    // divider operand selection
    always_comb begin
        div_go = ctrl.k_load || ctrl.m_load;
        if (ctrl.m_load) begin
            div_rem   = '0;
            div_dvd   = QW'(map_num) << (QW - NUM_W);
            div_dsr   = DIV_W'(den_mag);
            div_steps = CNT_W'(NUM_W);
        end else begin
            div_rem   = DIV_W'(r_e >> 1);
            div_dvd   = QW'(r_e[0]) << (QW - 1);
            div_dsr   = k_sum;
            div_steps = CNT_W'(GAIN_W);
        end
    end

    pksu_div #(
        .QUO_W (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (div_go),
        .i_rem   (div_rem),
        .i_dvd   (div_dvd),
        .i_dsr   (div_dsr),
        .i_steps (div_steps),
        .o_quo   (div_quo),
        .o_busy  (stat.div_busy),
        .o_done  (stat.div_done)
    );

    // multiplier operand selection
    always_comb begin
        case (ctrl.mul_op)
            MUL_STEP: begin
                mul_a = A_W'(r_d);
                mul_b = k_val;
            end
            MUL_ERR: begin
                mul_a = A_W'(r_e);
                mul_b = GAIN_ONE - r_k;
            end
            MUL_NOISE_HI: begin
                mul_a = A_W'(r_step);
                mul_b = GAIN_W'(r_noise_q[ERR_W-1:GAIN_FRAC]);
            end
            MUL_NOISE_LO: begin
                mul_a = A_W'(r_step);
                mul_b = GAIN_W'(r_noise_q[GAIN_FRAC-1:0]);
            end
            default: begin
                mul_a = A_W'(r_d);
                mul_b = k_val;
            end
        endcase
    end

    pksu_mul #(
        .A_W (A_W),
        .B_W (GAIN_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // noise term and error sum, each saturated to 32 bits
    always_comb begin
        step_val    = prod[HP_W-1:GAIN_FRAC];
        hi_ovf      = |r_hi_prod[HP_W-1:GAIN_FRAC+FRAC_BITS];
        noise_total = (TW'(r_hi_prod) << GAIN_FRAC) + TW'(prod[HP_W-1:0]);
        noise_shift = noise_total[TW-1:FRAC_BITS];
        err_sum     = {1'b0, r_ne1} + {1'b0, r_noise};
    end

    // working datapath registers
    always_ff @(posedge i_clk) begin
        if (item_fire) begin
            r_now <= i_item.now_ms;
            r_v   <= clamped;
        end
        if (ctrl.k_load) begin
            r_sum_zero <= k_sum == '0;
            r_up       <= target >= r_x;
            r_d        <= (target >= r_x) ? (target - r_x) : (r_x - target);
        end
        if (ctrl.k_latch) begin
            r_k <= k_val;
        end
        if (ctrl.x_upd) begin
            r_step <= step_val;
        end
        if (ctrl.ne1_upd) begin
            r_ne1 <= prod[ERR_W+GAIN_FRAC-1:GAIN_FRAC];
        end
        if (ctrl.hi_upd) begin
            r_hi_prod <= prod[HP_W-1:0];
        end
        if (ctrl.noise_upd) begin
            r_noise <= (hi_ovf || noise_shift[ERR_W]) ? '1 : noise_shift[ERR_W-1:0];
        end
        if (ctrl.m_load) begin
            r_map_zero <= (den_mag == '0) || ((num_mag != '0) && (num_neg != den_neg));
        end
    end

    // filter state; an initial-error write reloads the estimate error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_x         <= '0;
            r_e         <= RST_INIT_ERR;
            r_held_f    <= '0;
            r_held_s    <= '0;
            r_out_taken <= 1'b0;
        end else begin
            if (item_fire) begin
                r_out_taken <= stat.take;
            end
            if (ctrl.x_upd) begin
                r_x <= r_up ? (r_x + step_val) : (r_x - step_val);
            end
            if (cfg_fire && (t_cfg_reg'(i_cfg.index) == REG_INIT_ERR)) begin
                r_e <= i_cfg.data[ERR_W-1:0];
            end else if (ctrl.e_upd) begin
                r_e <= err_sum[ERR_W] ? '1 : err_sum[ERR_W-1:0];
            end
            if (ctrl.e_upd) begin
                r_held_f <= r_x[EST_W-1:FRAC_BITS];
                r_last   <= r_now;
            end
            if (ctrl.s_upd) begin
                if (r_map_zero) begin
                    r_held_s <= '0;
                end else if (|div_quo[QW-1:MAP_BITS]) begin
                    r_held_s <= MAP_MAX;
                end else begin
                    r_held_s <= div_quo[MAP_BITS-1:0];
                end
            end
        end
    end

    // drive the result word
    assign o_result.valid          = ctrl.out_valid;
    assign o_result.taken          = r_out_taken;
    assign o_result.filtered_value = r_held_f;
    assign o_result.scaled_value   = r_held_s;

    // checks
    `PKSU_ASSERT_NEXT(a_accept_drops_ready, item_fire, !i_item.ready, "ready stayed high after accept")
    `PKSU_ASSERT_IMPL(a_div_start_idle, div_go, !stat.div_busy, "divider started while busy")
    `PKSU_ASSERT_NEXT(a_result_frees_input, o_result.valid && o_result.ready, i_item.ready, "input not reopened after result")
    `PKSU_ASSERT_NEXT(a_skip_keeps_hold, item_fire && !stat.take, $stable(r_held_f) && $stable(r_held_s) && $stable(r_x), "held values changed on skipped word")

endmodule
